FILE: rtl/fixed_block_pool_allocator_macros.svh
// ----------------------------------------------------------------------------
// fixed block pool allocator assertion macros
// shared concurrent assertion forms used by the rtl files
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// condition holds at every clock edge outside reset
`define FBPA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("fbpa assertion failed");

// antecedent implies consequent in the same cycle
`define FBPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fbpa assertion failed");

// antecedent implies consequent in the next cycle
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fbpa assertion failed");

`endif

FILE: rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// request and response types, command, status and register codes of the
// fixed block pool allocator
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

	// request payload
	typedef struct packed {
		logic [1:0] command;
		logic [7:0] block_index;
	} in_t;

	// response payload
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  given_index;
		logic [31:0] given_address;
		logic [8:0]  blocks_free;
	} out_t;

	// commands
	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_FREE   = 2'd1;
	localparam logic [1:0] CMD_REINIT = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_REJECT = 2'd2;

	// register indexes
	localparam logic [1:0] REG_POOL_BASE   = 2'd0;
	localparam logic [1:0] REG_BLOCK_BYTES = 2'd1;
	localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;

	// register reset values
	localparam logic [31:0] POOL_BASE_RST   = 32'd0;
	localparam logic [15:0] BLOCK_BYTES_RST = 16'd4;
	localparam logic [8:0]  BLOCK_COUNT_RST = 9'd256;
	localparam int          COUNT_RESET     = 256;

	// block size rounding to a multiple of four
	localparam logic [16:0] ROUND_ADD = 17'h00003;

	// shared adder operations
	typedef logic [1:0] alu_op_t;
	localparam alu_op_t ALU_ADD = 2'd0;
	localparam alu_op_t ALU_INC = 2'd1;
	localparam alu_op_t ALU_DEC = 2'd2;

	typedef struct packed {
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

endpackage

`default_nettype wire

FILE: rtl/fbpa_alu.sv
// ----------------------------------------------------------------------------
// fbpa_alu
// shared 32-bit adder: address accumulation, walk index and free count steps
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_alu (
	input  fbpa_pkg::alu_req_t req,
	output logic [31:0]        y
);
	import fbpa_pkg::*;

	// operand selection into one adder
	always_comb begin
		case (req.op)
			ALU_ADD: y = req.a + req.b;
			ALU_INC: y = req.a + 32'd1;
			ALU_DEC: y = req.a + 32'hFFFF_FFFF;
			default: y = req.a;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/fbpa_link_mem.sv
// ----------------------------------------------------------------------------
// fbpa_link_mem
// free list link store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_link_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/fixed_block_pool_allocator.sv
// allocate: multiply state, a shift-and-add address multiply on the shared
//   adder (one index bit a cycle), then count and done; free: count, then done
// empty, rejected and undefined commands: done; reinitialise: walk, one link
//   store entry written a cycle, then done (done at once for zero blocks)
// after reset the link store is relinked over min(256, MAX_BLOCKS) entries,
//   during which no request is taken; one request is in flight at a time
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// fixed-size block pool kept as a lifo free list of block indices with a
// link store, a list head and a free count
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_en,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  fbpa_pkg::in_t    in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output fbpa_pkg::out_t   out_data
);
	import fbpa_pkg::*;

	localparam int IW      = $clog2(MAX_BLOCKS);
	localparam int CW      = $clog2(MAX_BLOCKS + 1);
	localparam int EW      = (CW > 8) ? CW : 8;
	localparam int RESET_N = (COUNT_RESET > MAX_BLOCKS) ? MAX_BLOCKS : COUNT_RESET;
	localparam logic [CW-1:0] NULL_LINK = CW'(MAX_BLOCKS);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WALK  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_COUNT = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [31:0]   pool_base_q;
	logic [15:0]   block_bytes_q;
	logic [8:0]    block_count_q;

	logic [2:0]    state_q;
	logic          boot_q;
	logic [1:0]    cmd_q;
	logic [1:0]    status_q;
	logic [CW-1:0] head_q;
	logic [CW-1:0] free_q;
	logic [CW-1:0] active_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] walk_n_q;
	logic [IW-1:0] mul_q;
	logic [31:0]   acc_q;
	logic [31:0]   sz_q;
	logic [7:0]    gidx_q;
	logic          out_valid_q;
	out_t          out_q;

	logic          accept;
	logic          alloc_empty;
	logic          free_bad;
	logic [EW-1:0] idx_ext;
	logic [CW-1:0] n_clamp;
	logic [16:0]   sz_sum;
	logic [31:0]   sz_round;
	logic [CW-1:0] nxt;
	logic [IW-1:0] mul_nxt;
	logic          out_free;

	alu_req_t      alu_req;
	logic [31:0]   alu_y;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [CW-1:0] mem_wdata;
	logic          mem_re;
	logic [CW-1:0] link_rd;

	// request decode
	assign accept      = in_valid && !in_stall;
	assign in_stall    = (state_q != ST_IDLE);
	assign alloc_empty = (free_q == '0) || (head_q >= NULL_LINK);
	assign idx_ext     = EW'(in_data.block_index);
	assign free_bad    = (free_q >= active_q) || (idx_ext >= EW'(active_q));
	assign n_clamp     = (32'(block_count_q) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
	                                                            : CW'(block_count_q);
	assign sz_sum      = {1'b0, block_bytes_q} + ROUND_ADD;
	assign sz_round    = {15'd0, sz_sum[16:2], 2'b00};
	assign nxt         = alu_y[CW-1:0];
	assign mul_nxt     = mul_q >> 1;
	assign out_free    = !out_valid_q || !out_stall;

	// shared adder operand selection
	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = acc_q;
		alu_req.b  = sz_q;
		case (state_q)
			ST_WALK: begin
				alu_req.op = ALU_INC;
				alu_req.a  = 32'(idx_q);
			end
			ST_COUNT: begin
				alu_req.op = (cmd_q == CMD_ALLOC) ? ALU_DEC : ALU_INC;
				alu_req.a  = 32'(free_q);
			end
			default: begin
				alu_req.op = ALU_ADD;
			end
		endcase
	end

	fbpa_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	// link store access
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[IW-1:0];
		mem_wdata = (nxt < walk_n_q) ? nxt : NULL_LINK;
		mem_re    = accept && (in_data.command == CMD_ALLOC);
		if (state_q == ST_WALK) begin
			mem_we = 1'b1;
		end else if (accept && (in_data.command == CMD_FREE) && !free_bad) begin
			mem_we    = 1'b1;
			mem_waddr = idx_ext[IW-1:0];
			mem_wdata = head_q;
		end
	end

	fbpa_link_mem #(
		.DEPTH (MAX_BLOCKS),
		.AW    (IW),
		.DW    (CW)
	) u_link_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (head_q[IW-1:0]),
		.rdata (link_rd)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= POOL_BASE_RST;
			block_bytes_q <= BLOCK_BYTES_RST;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (cfg_en) begin
			case (cfg_index)
				REG_POOL_BASE:   pool_base_q   <= cfg_data;
				REG_BLOCK_BYTES: block_bytes_q <= cfg_data[15:0];
				REG_BLOCK_COUNT: block_count_q <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WALK;
			boot_q      <= 1'b1;
			cmd_q       <= CMD_ALLOC;
			status_q    <= STAT_OK;
			head_q      <= '0;
			free_q      <= CW'(RESET_N);
			active_q    <= CW'(RESET_N);
			idx_q       <= '0;
			walk_n_q    <= CW'(RESET_N);
			out_valid_q <= 1'b0;
		end else begin
			// response handshake
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q <= in_data.command;
						case (in_data.command)
							CMD_ALLOC: begin
								if (alloc_empty) begin
									status_q <= STAT_EMPTY;
									state_q  <= ST_DONE;
								end else begin
									status_q <= STAT_OK;
									state_q  <= ST_MUL;
								end
							end
							CMD_FREE: begin
								if (free_bad) begin
									status_q <= STAT_REJECT;
									state_q  <= ST_DONE;
								end else begin
									status_q <= STAT_OK;
									head_q   <= idx_ext[CW-1:0];
									state_q  <= ST_COUNT;
								end
							end
							CMD_REINIT: begin
								status_q <= STAT_OK;
								if (n_clamp == '0) begin
									head_q   <= NULL_LINK;
									free_q   <= '0;
									active_q <= '0;
									state_q  <= ST_DONE;
								end else begin
									idx_q    <= '0;
									walk_n_q <= n_clamp;
									state_q  <= ST_WALK;
								end
							end
							default: begin
								status_q <= STAT_REJECT;
								state_q  <= ST_DONE;
							end
						endcase
					end
				end
				ST_WALK: begin
					idx_q <= nxt;
					if (nxt >= walk_n_q) begin
						head_q   <= '0;
						free_q   <= walk_n_q;
						active_q <= walk_n_q;
						boot_q   <= 1'b0;
						state_q  <= boot_q ? ST_IDLE : ST_DONE;
					end
				end
				ST_MUL: begin
					if (mul_nxt == '0) begin
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					free_q <= alu_y[CW-1:0];
					if (cmd_q == CMD_ALLOC) begin
						head_q <= link_rd;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// address datapath: shift-and-add of index times rounded size
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((in_data.command == CMD_ALLOC) && !alloc_empty) begin
						acc_q  <= pool_base_q;
						gidx_q <= 8'(head_q);
					end else begin
						acc_q  <= '0;
						gidx_q <= '0;
					end
					sz_q  <= sz_round;
					mul_q <= head_q[IW-1:0];
				end
			end
			ST_MUL: begin
				if (mul_q[0]) begin
					acc_q <= alu_y;
				end
				sz_q  <= sz_q << 1;
				mul_q <= mul_nxt;
			end
			default: begin
			end
		endcase
	end

	// response register
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_q.status        <= status_q;
			out_q.given_index   <= gidx_q;
			out_q.given_address <= acc_q;
			out_q.blocks_free   <= 9'(free_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	`FBPA_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE)
	`FBPA_ASSERT_SAME(a_free_within_pool, clk, arst_n, state_q == ST_IDLE, free_q <= active_q)
	`FBPA_ASSERT_SAME(a_boot_no_response, clk, arst_n, boot_q, !out_valid_q)
	`FBPA_ASSERT_SAME(a_mul_only_alloc, clk, arst_n, state_q == ST_MUL, cmd_q == CMD_ALLOC)

endmodule

`default_nettype wire
